// ===== rtl/projective_pixel_warp_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PROJECTIVE_PIXEL_WARP_ASSERT_SVH
`define PROJECTIVE_PIXEL_WARP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PPW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PPW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== rtl/pwarp_pkg.sv =====
// ----------------------------------------------------------------------------
// pwarp_pkg
// Shared constants and types of the projective pixel warp.
// ----------------------------------------------------------------------------
`default_nettype none
package pwarp_pkg;
    localparam int DEST_COLS = 1024;
    localparam int DEST_ROWS = 1024;
    localparam int FRAC_BITS = 32;

    localparam int COEF_W  = 48;
    localparam int POS_W   = 12;
    localparam int PROD_W  = COEF_W + POS_W + 1;
    localparam int SUM_W   = 62;
    localparam int QBITS   = POS_W + 1;
    localparam int DVS_W   = SUM_W + POS_W;
    localparam int NUM_COEFS = 8;
    localparam int IDX_W   = 3;
    localparam int RGB_W   = 24;

    // register indexes
    localparam logic [IDX_W-1:0] REG_XX = 3'd0;
    localparam logic [IDX_W-1:0] REG_XY = 3'd1;
    localparam logic [IDX_W-1:0] REG_XT = 3'd2;
    localparam logic [IDX_W-1:0] REG_YX = 3'd3;
    localparam logic [IDX_W-1:0] REG_YY = 3'd4;
    localparam logic [IDX_W-1:0] REG_YT = 3'd5;
    localparam logic [IDX_W-1:0] REG_WX = 3'd6;
    localparam logic [IDX_W-1:0] REG_WY = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << FRAC_BITS);

    typedef logic signed [COEF_W-1:0] coef_t;

    // One pixel on its way through the divider chain
    typedef struct packed {
        logic              vld;
        logic [SUM_W-1:0]  rem_x;
        logic [SUM_W-1:0]  rem_y;
        logic [DVS_W-1:0]  dvs;
        logic [QBITS-1:0]  q_x;
        logic [QBITS-1:0]  q_y;
        logic              neg_x;
        logic              neg_y;
        logic              w_zero;
        logic [RGB_W-1:0]  rgb;
    } cell_t;
endpackage
`default_nettype wire

// ===== rtl/pwarp_mac.sv =====
// ----------------------------------------------------------------------------
// pwarp_mac
// Two-stage multiply and sum forming X, Y and W of one pixel.
// ----------------------------------------------------------------------------
`default_nettype none
module pwarp_mac (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic                              in_vld,
    input  wire logic [pwarp_pkg::POS_W-1:0]       col,
    input  wire logic [pwarp_pkg::POS_W-1:0]       row,
    input  wire logic [pwarp_pkg::RGB_W-1:0]       rgb_in,
    input  wire pwarp_pkg::coef_t                  coef [pwarp_pkg::NUM_COEFS],
    output logic                                   out_vld,
    output logic signed [pwarp_pkg::SUM_W-1:0]     x_out,
    output logic signed [pwarp_pkg::SUM_W-1:0]     y_out,
    output logic signed [pwarp_pkg::SUM_W-1:0]     w_out,
    output logic [pwarp_pkg::RGB_W-1:0]            rgb_out
);
    import pwarp_pkg::*;

    localparam logic signed [SUM_W-1:0] W_ONE = SUM_W'(64'd1 << FRAC_BITS);

    logic signed [POS_W:0]    col_s, row_s;
    logic signed [PROD_W-1:0] p_next [6];
    logic signed [PROD_W-1:0] p_reg  [6];
    logic                     vld1_reg, vld2_reg;
    logic [RGB_W-1:0]         rgb1_reg, rgb2_reg;
    logic signed [SUM_W-1:0]  x_reg, y_reg, w_reg;

    assign col_s = $signed({1'b0, col});
    assign row_s = $signed({1'b0, row});

    // form the six products
    assign p_next[0] = coef[REG_XX] * col_s;
    assign p_next[1] = coef[REG_XY] * row_s;
    assign p_next[2] = coef[REG_YX] * col_s;
    assign p_next[3] = coef[REG_YY] * row_s;
    assign p_next[4] = coef[REG_WX] * col_s;
    assign p_next[5] = coef[REG_WY] * row_s;

    // hold valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    // register products, then sums
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg    <= p_next;
            rgb1_reg <= rgb_in;
            x_reg    <= SUM_W'(p_reg[0]) + SUM_W'(p_reg[1]) + SUM_W'(coef[REG_XT]);
            y_reg    <= SUM_W'(p_reg[2]) + SUM_W'(p_reg[3]) + SUM_W'(coef[REG_YT]);
            w_reg    <= SUM_W'(p_reg[4]) + SUM_W'(p_reg[5]) + W_ONE;
            rgb2_reg <= rgb1_reg;
        end
    end

    assign out_vld = vld2_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign w_out   = w_reg;
    assign rgb_out = rgb2_reg;
endmodule
`default_nettype wire

// ===== rtl/pwarp_div_cell.sv =====
// ----------------------------------------------------------------------------
// pwarp_div_cell
// One restoring-division step for both quotients; divisor halves per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module pwarp_div_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire pwarp_pkg::cell_t cin,
    output pwarp_pkg::cell_t      cout
);
    import pwarp_pkg::*;

    logic  ge_x, ge_y;
    logic  vld_reg;
    cell_t data_next, data_reg;

    assign ge_x = {{POS_W{1'b0}}, cin.rem_x} >= cin.dvs;
    assign ge_y = {{POS_W{1'b0}}, cin.rem_y} >= cin.dvs;

    // subtract where the divisor fits, shift in the quotient bit
    always_comb begin
        data_next       = cin;
        data_next.rem_x = ge_x ? cin.rem_x - cin.dvs[SUM_W-1:0] : cin.rem_x;
        data_next.rem_y = ge_y ? cin.rem_y - cin.dvs[SUM_W-1:0] : cin.rem_y;
        data_next.q_x   = {cin.q_x[QBITS-2:0], ge_x};
        data_next.q_y   = {cin.q_y[QBITS-2:0], ge_y};
        data_next.dvs   = cin.dvs >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= cin.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        cout     = data_reg;
        cout.vld = vld_reg;
    end
endmodule
`default_nettype wire

// ===== rtl/projective_pixel_warp.sv =====
// ----------------------------------------------------------------------------
// projective_pixel_warp
// Forward homography warp of a pixel stream with in-frame filtering.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle whenever the sink takes results. Its pipeline is
// the multiply and sum, a magnitude register, thirteen division cells
// (one quotient bit each, X and Y side by side) and the output register.
// The division cell chain is its longest part. Pixels that land outside the
// frame, or whose W is zero, produce no result. Coefficients are written
// through the cfg port (always ready); the user must write them only while
// the stream is idle, and the block itself does not enforce this.
`default_nettype none
module projective_pixel_warp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // src_col, src_row, red_in, green_in, blue_in
    input  wire logic [47:0]                    s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // dst_col, dst_row, red_out, green_out, blue_out
    output logic [47:0]                         m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pwarp_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [pwarp_pkg::COEF_W-1:0]   cfg_data
);
    import pwarp_pkg::*;

    coef_t                   coef_reg [NUM_COEFS];
    logic                    en;
    logic                    mac_vld;
    logic signed [SUM_W-1:0] x_s, y_s, w_s;
    logic [RGB_W-1:0]        mac_rgb;
    cell_t                   head_next;
    logic                    head_vld_reg;
    cell_t                   head_reg;
    cell_t                   chain [QBITS+1];
    cell_t                   last;
    logic                    keep;
    logic                    m_tvalid_reg;
    logic [47:0]             m_tdata_reg;

    // advance everything unless a result is waiting and the sink does not take it
    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                coef_reg[i] <= (i == int'(REG_XX) || i == int'(REG_YY)) ? COEF_ONE : '0;
            end
        end else if (cfg_valid) begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    pwarp_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .col     (s_tdata[11:0]),
        .row     (s_tdata[23:12]),
        .rgb_in  (s_tdata[47:24]),
        .coef    (coef_reg),
        .out_vld (mac_vld),
        .x_out   (x_s),
        .y_out   (y_s),
        .w_out   (w_s),
        .rgb_out (mac_rgb)
    );

    // take magnitudes and signs, align the divisor to the top quotient bit
    always_comb begin
        head_next        = '0;
        head_next.vld    = mac_vld;
        head_next.rem_x  = x_s[SUM_W-1] ? SUM_W'(-x_s) : SUM_W'(x_s);
        head_next.rem_y  = y_s[SUM_W-1] ? SUM_W'(-y_s) : SUM_W'(y_s);
        head_next.dvs    = {(w_s[SUM_W-1] ? SUM_W'(-w_s) : SUM_W'(w_s)), {POS_W{1'b0}}};
        head_next.neg_x  = x_s[SUM_W-1] ^ w_s[SUM_W-1];
        head_next.neg_y  = y_s[SUM_W-1] ^ w_s[SUM_W-1];
        head_next.w_zero = (w_s == '0);
        head_next.rgb    = mac_rgb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_vld_reg <= 1'b0;
        end else if (en) begin
            head_vld_reg <= head_next.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            head_reg <= head_next;
        end
    end

    always_comb begin
        chain[0]     = head_reg;
        chain[0].vld = head_vld_reg;
    end

    // division cell chain
    for (genvar k = 0; k < QBITS; k++) begin : g_cell
        pwarp_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .cin     (chain[k]),
            .cout    (chain[k+1])
        );
    end

    assign last = chain[QBITS];

    // drop zero W, negative or out-of-frame destinations
    assign keep = !last.w_zero
               && !(last.neg_x && last.q_x != '0)
               && !(last.neg_y && last.q_y != '0)
               && ({1'b0, last.q_x} < (QBITS+1)'(DEST_COLS))
               && ({1'b0, last.q_y} < (QBITS+1)'(DEST_ROWS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= last.vld && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {last.rgb, last.q_y[POS_W-1:0], last.q_x[POS_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule
`default_nettype wire

// ===== rtl/pwarp_checker.sv =====
// ----------------------------------------------------------------------------
// pwarp_checker
// Port-level checks of the projective pixel warp, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "projective_pixel_warp_assert.svh"
module pwarp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);
    import pwarp_pkg::*;

    localparam logic [POS_W:0] COL_LIM = (POS_W+1)'(DEST_COLS);
    localparam logic [POS_W:0] ROW_LIM = (POS_W+1)'(DEST_ROWS);

    `PPW_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result request dropped")
    `PPW_ASSERT(a_col_in_frame, m_tvalid |-> {1'b0, m_tdata[11:0]} < COL_LIM, "column outside")
    `PPW_ASSERT(a_row_in_frame, m_tvalid |-> {1'b0, m_tdata[23:12]} < ROW_LIM, "row outside")
    `PPW_ASSERT(a_stall_blocks, m_tvalid && !m_tready |-> !s_tready, "input taken in stall")
    `PPW_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result valid after reset")
endmodule

bind projective_pixel_warp pwarp_checker u_pwarp_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams source pixels through the projective warp under several homographies
// and checks every in-frame destination against a behavioral prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Predicts the warped destination of each accepted pixel and checks results
class warp_scoreboard;
    typedef struct {
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } dest_pixel_t;

    longint      coef[8];
    dest_pixel_t pending_q[$];
    int          errors;

    function new();
        foreach (coef[i]) coef[i] = 0;
        coef[pwarp_pkg::REG_XX] = longint'(1) << pwarp_pkg::FRAC_BITS;
        coef[pwarp_pkg::REG_YY] = longint'(1) << pwarp_pkg::FRAC_BITS;
        errors = 0;
    endfunction

    function void set_coef(logic [2:0] idx, logic [47:0] val);
        coef[idx] = longint'(signed'(val));
    endfunction

    // Map one accepted pixel; queue a destination if it lands in frame
    function void note_pixel(logic [47:0] data);
        longint c, r, x, y, w, dc, dr;
        dest_pixel_t d;
        c = longint'(data[11:0]);
        r = longint'(data[23:12]);
        x = coef[pwarp_pkg::REG_XX] * c + coef[pwarp_pkg::REG_XY] * r
            + coef[pwarp_pkg::REG_XT];
        y = coef[pwarp_pkg::REG_YX] * c + coef[pwarp_pkg::REG_YY] * r
            + coef[pwarp_pkg::REG_YT];
        w = coef[pwarp_pkg::REG_WX] * c + coef[pwarp_pkg::REG_WY] * r
            + (longint'(1) << pwarp_pkg::FRAC_BITS);
        if (w == 0) return;
        dc = x / w;
        dr = y / w;
        if (dc < 0 || dc >= pwarp_pkg::DEST_COLS || dr < 0 || dr >= pwarp_pkg::DEST_ROWS)
            return;
        d.col = dc[11:0];
        d.row = dr[11:0];
        d.red = data[31:24];
        d.green = data[39:32];
        d.blue = data[47:40];
        pending_q.push_back(d);
    endfunction

    function void check_result(logic [47:0] data);
        dest_pixel_t e;
        if (pending_q.size() == 0) begin
            $error("unexpected result %h", data);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (data[11:0] !== e.col) begin
            $error("dst_col expected %0d actual %0d", e.col, data[11:0]);
            errors++;
        end
        if (data[23:12] !== e.row) begin
            $error("dst_row expected %0d actual %0d", e.row, data[23:12]);
            errors++;
        end
        if (data[31:24] !== e.red) begin
            $error("red_out expected %0d actual %0d", e.red, data[31:24]);
            errors++;
        end
        if (data[39:32] !== e.green) begin
            $error("green_out expected %0d actual %0d", e.green, data[39:32]);
            errors++;
        end
        if (data[47:40] !== e.blue) begin
            $error("blue_out expected %0d actual %0d", e.blue, data[47:40]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import pwarp_pkg::*;

    localparam int  LATENCY   = 17;
    localparam longint ONE    = longint'(1) << FRAC_BITS;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // src_col, src_row, red_in, green_in, blue_in
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // dst_col, dst_row, red_out, green_out, blue_out
    logic        cfg_valid;
    logic        cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [COEF_W-1:0] cfg_data;

    warp_scoreboard sb;
    longint cycles;
    bit     hold_sink;
    bit     long_hold_req;

    projective_pixel_warp u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Count cycles and stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check each accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Sink: random stalls, plus one long hold-off on request
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                long_hold_req = 1'b0;
            end
            if (!hold_sink && $urandom_range(0, 3) == 0) begin
                n = gap_len();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
        end
    end

    // Write one coefficient register
    task automatic write_coef(logic [IDX_W-1:0] idx, longint val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[COEF_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_coef(idx, val[COEF_W-1:0]);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_matrix(longint xx, xy, xt, yx, yy, yt, wx, wy);
        write_coef(REG_XX, xx);
        write_coef(REG_XY, xy);
        write_coef(REG_XT, xt);
        write_coef(REG_YX, yx);
        write_coef(REG_YY, yy);
        write_coef(REG_YT, yt);
        write_coef(REG_WX, wx);
        write_coef(REG_WY, wy);
    endtask

    // Offer one pixel; gaps optional
    task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [23:0] rgb, bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {rgb, row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_pixel({rgb, row, col});
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Pause until every expected destination has arrived and the pipe drains
    task automatic drain();
        idle_input();
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic longint rand_coef(longint span);
        longint v;
        v = longint'({$urandom, $urandom}) % span;
        return v;
    endfunction

    function automatic logic [11:0] rand_pos();
        if ($urandom_range(0, 3) == 0) return 12'($urandom);
        return 12'($urandom_range(0, 1100));
    endfunction

    // Random phase with one matrix
    task automatic random_phase(int count, bit long_hold);
        for (int i = 0; i < count; i++) begin
            if (long_hold && i == 10) long_hold_req = 1'b1;
            send_pixel(rand_pos(), rand_pos(), 24'($urandom), !(long_hold && i < 200));
        end
        drain();
    endtask

    initial begin
        sb = new();
        cycles = 0;
        hold_sink = 1'b0;
        long_hold_req = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: identity at reset, frame edges and field extremes
        send_pixel(12'd0, 12'd0, 24'h000000, 0);
        send_pixel(12'd1023, 12'd1023, 24'hFFFFFF, 0);
        send_pixel(12'd1024, 12'd5, 24'hA5A55A, 0);
        send_pixel(12'd5, 12'd1024, 24'h5A5AA5, 0);
        send_pixel(12'd4095, 12'd4095, 24'hFF00FF, 0);
        send_pixel(12'hAAA, 12'h555, 24'h123456, 0);
        send_pixel(12'h555, 12'hAAA, 24'hEDCBA9, 0);
        drain();

        // Negative shift: small negative quotient truncates to zero
        load_matrix(ONE, 0, -(ONE / 2), 0, ONE, -(ONE / 2), 0, 0);
        send_pixel(12'd0, 12'd0, 24'h010203, 0);
        send_pixel(12'd1, 12'd1, 24'h040506, 0);
        send_pixel(12'd1024, 12'd1024, 24'h070809, 0);
        drain();

        // Zero denominator: W = 1 - c/16 is zero at column 16
        load_matrix(ONE, 0, 0, 0, ONE, 0, -(ONE / 16), 0);
        send_pixel(12'd16, 12'd3, 24'h111111, 0);
        send_pixel(12'd15, 12'd3, 24'h222222, 0);
        send_pixel(12'd17, 12'd3, 24'h333333, 0);
        drain();
        load_matrix(-ONE, 0, 1023 * ONE, 0, -ONE, 1023 * ONE, 0, -(ONE / 8));
        send_pixel(12'd0, 12'd8, 24'h444444, 0);
        send_pixel(12'd7, 12'd0, 24'h555555, 0);
        send_pixel(12'd0, 12'd9, 24'h666666, 0);
        drain();

        // Extremes of the coefficient range
        load_matrix((longint'(1) <<< 47) - 1, -(longint'(1) <<< 47), 0,
                    -(longint'(1) <<< 47), (longint'(1) <<< 47) - 1, 0,
                    (longint'(1) <<< 47) - 1, -(longint'(1) <<< 47));
        send_pixel(12'd4095, 12'd0, 24'h777777, 0);
        send_pixel(12'd0, 12'd4095, 24'h888888, 0);
        send_pixel(12'd4095, 12'd4095, 24'h999999, 0);
        send_pixel(12'd1, 12'd1, 24'hAAAAAA, 0);
        drain();

        // Identity with long sink hold-off: fill the pipe and stall input
        load_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0);
        random_phase(400, 1);

        // Random matrices: mostly near-affine, some perspective, some wild
        for (int ph = 0; ph < 7; ph++) begin
            longint s;
            s = (ph % 3 == 2) ? (longint'(1) << 47) : (ONE / 4);
            load_matrix(ONE / 2 + rand_coef(ONE), rand_coef(s), rand_coef(300 * ONE),
                        rand_coef(s), ONE / 2 + rand_coef(ONE), rand_coef(300 * ONE),
                        (ph % 2) ? rand_coef(ONE / 2048) : 0,
                        (ph % 2) ? rand_coef(ONE / 2048) : 0);
            random_phase(200, 0);
        end

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
